// File: sv/aff_inv_pkg.sv
// Shared widths, types and codes for the affine 3x4 inverse core.
// No dependencies; every other file takes names from here by scope.
package aff_inv_pkg;

    localparam int DATA_W = 32;
    localparam int PROD_W = 64;
    localparam int TERM_W = 96;
    localparam int SUM_W  = 98;
    localparam int DEN_W  = SUM_W + 1;
    localparam int REM_W  = DEN_W + 1;
    localparam int QUO_W  = 32;
    localparam int NUM_W  = REM_W + QUO_W;
    localparam int LANES  = 4;
    localparam int ROW_W  = 2;
    localparam int DIV_LAT = QUO_W + 1;

    localparam logic [ROW_W-1:0] ROW_FIRST = 2'd0;
    localparam logic [ROW_W-1:0] ROW_MID   = 2'd1;
    localparam logic [ROW_W-1:0] ROW_LAST  = 2'd2;

    localparam logic [DATA_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_NEG = 32'h8000_0000;

    typedef logic signed [DATA_W-1:0] t_word;

    typedef struct packed {
        logic [ROW_W-1:0] row_index;
        logic             singular;
        logic [LANES-1:0] neg;
    } t_side;

endpackage

// File: sv/aff_inv_if.sv
// Handshake interfaces for the matrix input channel and the row result channel.
// Depends on aff_inv_pkg for the word type.
interface aff_inv_mat_if;
    logic               valid;
    logic               ready;
    aff_inv_pkg::t_word a_r0c0;
    aff_inv_pkg::t_word a_r0c1;
    aff_inv_pkg::t_word a_r0c2;
    aff_inv_pkg::t_word a_r0t;
    aff_inv_pkg::t_word a_r1c0;
    aff_inv_pkg::t_word a_r1c1;
    aff_inv_pkg::t_word a_r1c2;
    aff_inv_pkg::t_word a_r1t;
    aff_inv_pkg::t_word a_r2c0;
    aff_inv_pkg::t_word a_r2c1;
    aff_inv_pkg::t_word a_r2c2;
    aff_inv_pkg::t_word a_r2t;

    modport source (output valid, a_r0c0, a_r0c1, a_r0c2, a_r0t, a_r1c0, a_r1c1, a_r1c2,
                    a_r1t, a_r2c0, a_r2c1, a_r2c2, a_r2t, input ready);
    modport sink (input valid, a_r0c0, a_r0c1, a_r0c2, a_r0t, a_r1c0, a_r1c1, a_r1c2,
                  a_r1t, a_r2c0, a_r2c1, a_r2c2, a_r2t, output ready);
endinterface

interface aff_inv_row_if;
    logic                                 valid;
    logic                                 ready;
    logic [aff_inv_pkg::ROW_W-1:0]        row_index;
    aff_inv_pkg::t_word                   inv_c0;
    aff_inv_pkg::t_word                   inv_c1;
    aff_inv_pkg::t_word                   inv_c2;
    aff_inv_pkg::t_word                   inv_t;
    logic                                 singular;
    logic                                 saturated;
    logic                                 last_row;

    modport source (output valid, row_index, inv_c0, inv_c1, inv_c2, inv_t, singular,
                    saturated, last_row, input ready);
    modport sink (input valid, row_index, inv_c0, inv_c1, inv_c2, inv_t, singular,
                  saturated, last_row, output ready);
endinterface

// File: sv/aff_inv_front.sv
// Seven-stage front end: cofactors, determinant, translation sums and divider operands.
// Depends on aff_inv_pkg; all stages advance together on i_en.
module aff_inv_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic [aff_inv_pkg::ROW_W-1:0]    i_row,
    input  aff_inv_pkg::t_word               i_a [3][4],
    output logic                             o_valid,
    output aff_inv_pkg::t_side               o_side,
    output logic [aff_inv_pkg::NUM_W-1:0]    o_num [aff_inv_pkg::LANES],
    output logic [aff_inv_pkg::DEN_W-1:0]    o_den
);

    localparam int NW = aff_inv_pkg::NUM_W;

    logic [6:0]                        r_vld;
    logic [aff_inv_pkg::ROW_W-1:0]     r_row [1:6];

    logic signed [63:0]                r1_pa [9];
    logic signed [63:0]                r1_pb [9];
    aff_inv_pkg::t_word                r1_a0 [3];
    aff_inv_pkg::t_word                r1_at [3];

    logic signed [63:0]                n_k [9];
    logic signed [63:0]                n_kc [3];
    logic signed [63:0]                r2_kc [3];
    logic signed [63:0]                r2_k0 [3];
    aff_inv_pkg::t_word                r2_a0 [3];
    aff_inv_pkg::t_word                r2_at [3];

    aff_inv_pkg::t_word                n_x [6];
    logic signed [63:0]                n_y [6];
    logic signed [63:0]                r3_hi [6];
    logic signed [64:0]                r3_lo [6];
    logic signed [63:0]                r3_kc [3];

    logic signed [aff_inv_pkg::TERM_W-1:0] r4_t [6];
    logic signed [63:0]                r4_kc [3];

    logic signed [aff_inv_pkg::SUM_W-1:0] r5_det;
    logic signed [aff_inv_pkg::SUM_W-1:0] r5_s;
    logic signed [63:0]                r5_kc [3];

    logic [aff_inv_pkg::SUM_W-1:0]     r6_dmag;
    logic [aff_inv_pkg::SUM_W-1:0]     r6_smag;
    logic [63:0]                       r6_kmag [3];
    logic                              r6_sing;
    logic [aff_inv_pkg::LANES-1:0]     r6_neg;

    logic                              n_dneg;
    logic                              n_tneg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[5:0], i_valid};
        end
    end

    always_comb begin
        for (int m = 0; m < 9; m++) begin
            n_k[m] = r1_pa[m] - r1_pb[m];
        end
        for (int j = 0; j < 3; j++) begin
            case (r_row[1])
                aff_inv_pkg::ROW_MID:  n_kc[j] = n_k[3 * j + 1];
                aff_inv_pkg::ROW_LAST: n_kc[j] = n_k[3 * j + 2];
                default:               n_kc[j] = n_k[3 * j];
            endcase
        end
        for (int p = 0; p < 3; p++) begin
            n_x[p]     = r2_a0[p];
            n_y[p]     = r2_k0[p];
            n_x[p + 3] = r2_at[p];
            n_y[p + 3] = r2_kc[p];
        end
        n_dneg = r5_det[aff_inv_pkg::SUM_W-1];
        n_tneg = !r5_s[aff_inv_pkg::SUM_W-1] && (r5_s != '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Stage 1: the eighteen cofactor products.
            r1_pa[0] <= i_a[1][1] * i_a[2][2];  r1_pb[0] <= i_a[1][2] * i_a[2][1];
            r1_pa[1] <= i_a[1][2] * i_a[2][0];  r1_pb[1] <= i_a[1][0] * i_a[2][2];
            r1_pa[2] <= i_a[1][0] * i_a[2][1];  r1_pb[2] <= i_a[1][1] * i_a[2][0];
            r1_pa[3] <= i_a[0][2] * i_a[2][1];  r1_pb[3] <= i_a[0][1] * i_a[2][2];
            r1_pa[4] <= i_a[0][0] * i_a[2][2];  r1_pb[4] <= i_a[0][2] * i_a[2][0];
            r1_pa[5] <= i_a[0][1] * i_a[2][0];  r1_pb[5] <= i_a[0][0] * i_a[2][1];
            r1_pa[6] <= i_a[0][1] * i_a[1][2];  r1_pb[6] <= i_a[0][2] * i_a[1][1];
            r1_pa[7] <= i_a[0][2] * i_a[1][0];  r1_pb[7] <= i_a[0][0] * i_a[1][2];
            r1_pa[8] <= i_a[0][0] * i_a[1][1];  r1_pb[8] <= i_a[0][1] * i_a[1][0];
            for (int j = 0; j < 3; j++) begin
                r1_a0[j] <= i_a[0][j];
                r1_at[j] <= i_a[j][3];
            end
            r_row[1] <= i_row;

            // Stage 2: cofactors, with the column of this row picked out.
            for (int j = 0; j < 3; j++) begin
                r2_kc[j] <= n_kc[j];
                r2_k0[j] <= n_k[j];
                r2_a0[j] <= r1_a0[j];
                r2_at[j] <= r1_at[j];
            end
            r_row[2] <= r_row[1];

            // Stage 3: each 32 by 64 product as two 32 by 32 halves.
            for (int p = 0; p < 6; p++) begin
                r3_hi[p] <= n_x[p] * $signed(n_y[p][63:32]);
                r3_lo[p] <= n_x[p] * $signed({1'b0, n_y[p][31:0]});
            end
            for (int j = 0; j < 3; j++) begin
                r3_kc[j] <= r2_kc[j];
            end
            r_row[3] <= r_row[2];

            // Stage 4: rejoin the halves.
            for (int p = 0; p < 6; p++) begin
                r4_t[p] <= {r3_hi[p], 32'd0} + {{31{r3_lo[p][64]}}, r3_lo[p]};
            end
            for (int j = 0; j < 3; j++) begin
                r4_kc[j] <= r3_kc[j];
            end
            r_row[4] <= r_row[3];

            // Stage 5: determinant and translation sum.
            r5_det <= aff_inv_pkg::SUM_W'(r4_t[0]) + aff_inv_pkg::SUM_W'(r4_t[1])
                    + aff_inv_pkg::SUM_W'(r4_t[2]);
            r5_s   <= aff_inv_pkg::SUM_W'(r4_t[3]) + aff_inv_pkg::SUM_W'(r4_t[4])
                    + aff_inv_pkg::SUM_W'(r4_t[5]);
            for (int j = 0; j < 3; j++) begin
                r5_kc[j] <= r4_kc[j];
            end
            r_row[5] <= r_row[4];

            // Stage 6: magnitudes and quotient signs.
            r6_dmag <= n_dneg ? aff_inv_pkg::SUM_W'(-r5_det) : aff_inv_pkg::SUM_W'(r5_det);
            r6_smag <= r5_s[aff_inv_pkg::SUM_W-1] ? aff_inv_pkg::SUM_W'(-r5_s)
                                                  : aff_inv_pkg::SUM_W'(r5_s);
            for (int j = 0; j < 3; j++) begin
                r6_kmag[j] <= r5_kc[j][63] ? 64'(-r5_kc[j]) : 64'(r5_kc[j]);
                r6_neg[j]  <= r5_kc[j][63] ^ n_dneg;
            end
            r6_neg[3] <= n_tneg ^ n_dneg;
            r6_sing   <= (r5_det == '0);
            r_row[6]  <= r_row[5];

            // Stage 7: rounding numerators 2|n| + |d| and divisor 2|d|.
            for (int j = 0; j < 3; j++) begin
                o_num[j] <= (NW'(r6_kmag[j]) << (2 * FRAC_BITS + 1)) + NW'(r6_dmag);
            end
            o_num[3] <= (NW'(r6_smag) << (FRAC_BITS + 1)) + NW'(r6_dmag);
            o_den    <= {r6_dmag, 1'b0};
            o_side.row_index <= r_row[6];
            o_side.singular  <= r6_sing;
            o_side.neg       <= r6_neg;
        end
    end

    assign o_valid = r_vld[6];

endmodule

// File: sv/aff_inv_div.sv
// Pipelined restoring divider lane: one quotient bit per stage plus an overflow check.
// Depends on aff_inv_pkg for operand widths.
module aff_inv_div (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [aff_inv_pkg::NUM_W-1:0]  i_num,
    input  logic [aff_inv_pkg::DEN_W-1:0]  i_den,
    output logic [aff_inv_pkg::QUO_W-1:0]  o_quo,
    output logic                           o_ovf
);

    localparam int QW = aff_inv_pkg::QUO_W;
    localparam int RW = aff_inv_pkg::REM_W;

    logic [RW-1:0]                     r_rem [0:QW];
    logic [QW-1:0]                     r_low [0:QW];
    logic [aff_inv_pkg::DEN_W-1:0]     r_den [0:QW];
    logic                              r_ovf [0:QW];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num[aff_inv_pkg::NUM_W-1:QW];
            r_low[0] <= i_num[QW-1:0];
            r_den[0] <= i_den;
            r_ovf[0] <= (i_num[aff_inv_pkg::NUM_W-1:QW] >= {1'b0, i_den});
        end
    end

    for (genvar g = 0; g < QW; g++) begin : g_step
        logic [RW-1:0] n_try;
        logic          n_ge;

        always_comb begin
            n_try = {r_rem[g][RW-2:0], r_low[g][QW-1]};
            n_ge  = (n_try >= {1'b0, r_den[g]});
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g+1] <= n_ge ? n_try - {1'b0, r_den[g]} : n_try;
                r_low[g+1] <= {r_low[g][QW-2:0], n_ge};
                r_den[g+1] <= r_den[g];
                r_ovf[g+1] <= r_ovf[g];
            end
        end
    end

    assign o_quo = r_low[QW];
    assign o_ovf = r_ovf[QW];

endmodule

// File: sv/affine_inverse_3x4_core.sv
// Affine 3x4 inverse core: the first row of a matrix passes the front end, the divider
// lanes and the output register, and the other two rows follow it in order.
// Each matrix is sent down the pipeline as three row items on consecutive unstalled
// cycles, and a new matrix is accepted only once all three are issued; four 33-stage
// divider lanes set the depth. An output stall freezes every stage. Reset (synchronous,
// active low) clears valid bits and the row sequencer only.
module affine_inverse_3x4_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    aff_inv_mat_if.sink   i_mat,
    aff_inv_row_if.source o_row
);

    localparam int LAT = aff_inv_pkg::DIV_LAT;
    localparam int QW  = aff_inv_pkg::QUO_W;

    logic                               w_adv;
    logic [aff_inv_pkg::ROW_W-1:0]      r_cnt;
    logic                               r_v0;
    logic [aff_inv_pkg::ROW_W-1:0]      r_row0;
    aff_inv_pkg::t_word                 r_mat [3][4];

    logic                               w_f_valid;
    aff_inv_pkg::t_side                 w_f_side;
    logic [aff_inv_pkg::NUM_W-1:0]      w_f_num [aff_inv_pkg::LANES];
    logic [aff_inv_pkg::DEN_W-1:0]      w_f_den;

    logic [QW-1:0]                      w_quo [aff_inv_pkg::LANES];
    logic                               w_ovf [aff_inv_pkg::LANES];

    logic [LAT-1:0]                     r_vld_d;
    aff_inv_pkg::t_side                 r_side_d [LAT];

    aff_inv_pkg::t_side                 w_side;
    logic [QW-1:0]                      n_val [aff_inv_pkg::LANES];
    logic [aff_inv_pkg::LANES-1:0]      n_sat;

    logic                               r_out_valid;
    logic [aff_inv_pkg::ROW_W-1:0]      r_out_row;
    logic [QW-1:0]                      r_out_val [aff_inv_pkg::LANES];
    logic                               r_out_sing;
    logic                               r_out_sat;

    assign w_adv       = !r_out_valid || o_row.ready;
    assign i_mat.ready = w_adv && (r_cnt == aff_inv_pkg::ROW_FIRST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= aff_inv_pkg::ROW_FIRST;
            r_v0  <= 1'b0;
        end else if (w_adv) begin
            if (r_cnt != aff_inv_pkg::ROW_FIRST) begin
                r_v0  <= 1'b1;
                r_cnt <= (r_cnt == aff_inv_pkg::ROW_LAST) ? aff_inv_pkg::ROW_FIRST
                                                           : r_cnt + 2'd1;
            end else if (i_mat.valid) begin
                r_v0  <= 1'b1;
                r_cnt <= aff_inv_pkg::ROW_MID;
            end else begin
                r_v0  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_row0 <= r_cnt;
            if (r_cnt == aff_inv_pkg::ROW_FIRST) begin
                r_mat[0][0] <= i_mat.a_r0c0;
                r_mat[0][1] <= i_mat.a_r0c1;
                r_mat[0][2] <= i_mat.a_r0c2;
                r_mat[0][3] <= i_mat.a_r0t;
                r_mat[1][0] <= i_mat.a_r1c0;
                r_mat[1][1] <= i_mat.a_r1c1;
                r_mat[1][2] <= i_mat.a_r1c2;
                r_mat[1][3] <= i_mat.a_r1t;
                r_mat[2][0] <= i_mat.a_r2c0;
                r_mat[2][1] <= i_mat.a_r2c1;
                r_mat[2][2] <= i_mat.a_r2c2;
                r_mat[2][3] <= i_mat.a_r2t;
            end
        end
    end

    aff_inv_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_v0),
        .i_row   (r_row0),
        .i_a     (r_mat),
        .o_valid (w_f_valid),
        .o_side  (w_f_side),
        .o_num   (w_f_num),
        .o_den   (w_f_den)
    );

    for (genvar g = 0; g < aff_inv_pkg::LANES; g++) begin : g_lane
        aff_inv_div u_div (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_num (w_f_num[g]),
            .i_den (w_f_den),
            .o_quo (w_quo[g]),
            .o_ovf (w_ovf[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_d <= '0;
        end else if (w_adv) begin
            r_vld_d <= {r_vld_d[LAT-2:0], w_f_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side_d[0] <= w_f_side;
            for (int s = 1; s < LAT; s++) begin
                r_side_d[s] <= r_side_d[s-1];
            end
        end
    end

    assign w_side = r_side_d[LAT-1];

    always_comb begin
        for (int l = 0; l < aff_inv_pkg::LANES; l++) begin
            if (w_side.singular) begin
                n_sat[l] = 1'b0;
                n_val[l] = '0;
            end else if (!w_side.neg[l]) begin
                n_sat[l] = w_ovf[l] || w_quo[l][QW-1];
                n_val[l] = n_sat[l] ? aff_inv_pkg::SAT_POS : w_quo[l];
            end else begin
                n_sat[l] = w_ovf[l] || (w_quo[l] > aff_inv_pkg::SAT_NEG);
                n_val[l] = n_sat[l] ? aff_inv_pkg::SAT_NEG : QW'(-w_quo[l]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_vld_d[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_row  <= w_side.row_index;
            r_out_sing <= w_side.singular;
            r_out_sat  <= |n_sat;
            for (int l = 0; l < aff_inv_pkg::LANES; l++) begin
                r_out_val[l] <= n_val[l];
            end
        end
    end

    assign o_row.valid     = r_out_valid;
    assign o_row.row_index = r_out_row;
    assign o_row.inv_c0    = r_out_val[0];
    assign o_row.inv_c1    = r_out_val[1];
    assign o_row.inv_c2    = r_out_val[2];
    assign o_row.inv_t     = r_out_val[3];
    assign o_row.singular  = r_out_sing;
    assign o_row.saturated = r_out_sat;
    assign o_row.last_row  = (r_out_row == aff_inv_pkg::ROW_LAST);

`ifndef SYNTHESIS
    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_row.valid && o_row.singular) |-> (o_row.inv_c0 == '0 && o_row.inv_c1 == '0
            && o_row.inv_c2 == '0 && o_row.inv_t == '0 && !o_row.saturated))
        else $error("singular row carries nonzero data");

    a_rows_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_row.valid && o_row.ready && !o_row.last_row) |=>
            (o_row.valid && o_row.row_index == $past(o_row.row_index) + 2'd1))
        else $error("inverse rows out of order or with a gap");

    a_accept_starts_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_mat.valid && i_mat.ready) |=> (r_v0 && r_row0 == aff_inv_pkg::ROW_FIRST
            && r_cnt == aff_inv_pkg::ROW_MID))
        else $error("accepted matrix did not start a row sequence");

    a_rows_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != aff_inv_pkg::ROW_FIRST && w_adv) |=> (r_v0 && !$past(i_mat.ready)))
        else $error("row sequencer dropped a row");
`endif

endmodule
